>>> sv/dfu_pkg.sv
// package: types, constants and arithmetic helpers of the dispersive field update core
package dfu_pkg;

    localparam int Q_SHIFT   = 24;
    localparam int PROD_W    = 64 - Q_SHIFT;   // width of a floored q8.24 product
    localparam int SUM_W     = 48;             // exact sum width before saturation
    localparam int CFG_IDX_W = 3;

    // pipeline stage numbering
    localparam int ST_IN    = 0;   // captured item, history read in flight
    localparam int ST_PROD  = 1;   // six products
    localparam int ST_SUM   = 2;   // q and divisor
    localparam int ST_AQ    = 3;   // amp * q
    localparam int ST_NUM   = 4;   // numerator
    localparam int ST_DSET  = 5;   // magnitudes, zero and overflow checks
    localparam int ST_DIV0  = 6;   // first divider stage
    localparam int DIV_STG  = 8;
    localparam int DIV_BITS = 4;   // quotient bits per divider stage
    localparam int ST_ENEW  = ST_DIV0 + DIV_STG;
    localparam int ST_B0E   = ST_ENEW + 1;
    localparam int NUM_STG  = ST_B0E + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 3'd0,
        REG_COEF_B0   = 3'd1,
        REG_COEF_B1   = 3'd2,
        REG_COEF_B2   = 3'd3,
        REG_COEF_A1   = 3'd4,
        REG_COEF_A2   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               flt;
    } sat_t;

    typedef struct packed {
        logic signed [31:0]       acc;
        logic signed [31:0]       e_now;
        logic signed [31:0]       e_prev;
        logic signed [31:0]       g_inf;
        logic signed [31:0]       amp;
        logic signed [31:0]       p1;
        logic signed [31:0]       p2;
        logic signed [PROD_W-1:0] pr_be;
        logic signed [PROD_W-1:0] pr_bp;
        logic signed [PROD_W-1:0] pr_a1;
        logic signed [PROD_W-1:0] pr_a2;
        logic signed [PROD_W-1:0] pr_dt;
        logic signed [PROD_W-1:0] pr_ab0;
        logic signed [PROD_W-1:0] pr_aq;
        logic signed [PROD_W-1:0] pr_b0e;
        logic signed [31:0]       q;
        logic signed [31:0]       den;
        logic signed [31:0]       num;
        logic [31:0]              rem;
        logic [31:0]              dsh;
        logic [31:0]              dvs;
        logic [31:0]              quo;
        logic                     neg;
        logic                     ovf;
        logic                     dz;
        logic signed [31:0]       e_new;
        logic                     fault;
    } st_t;

    // q8.24 product, floored
    function automatic logic signed [PROD_W-1:0] qmul(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:Q_SHIFT];
    endfunction

    function automatic sat_t sat32(logic signed [SUM_W-1:0] x);
        sat_t r;
        if (x > SUM_W'(64'sd2147483647)) begin
            r.val = 32'sh7FFFFFFF;
            r.flt = 1'b1;
        end else if (x < -SUM_W'(64'sd2147483648)) begin
            r.val = 32'sh80000000;
            r.flt = 1'b1;
        end else begin
            r.val = x[31:0];
            r.flt = 1'b0;
        end
        return r;
    endfunction

    // restoring division, DIV_BITS quotient bits msb first
    function automatic st_t div_stage(st_t s);
        st_t        r;
        logic [32:0] t;
        r = s;
        for (int i = 0; i < DIV_BITS; i++) begin
            t     = {r.rem, r.dsh[31]};
            r.dsh = {r.dsh[30:0], 1'b0};
            if (t >= {1'b0, r.dvs}) begin
                t     = t - {1'b0, r.dvs};
                r.quo = {r.quo[30:0], 1'b1};
            end else begin
                r.quo = {r.quo[30:0], 1'b0};
            end
            r.rem = t[31:0];
        end
        return r;
    endfunction

endpackage

>>> sv/dispersive_field_update_core.sv
// top level: pipelined dispersive medium field update with per-point polarization history
//
//  channel   ports         direction  item
//  input     s_axis_*      in         point_slot, flux, field now/before, g_inf, amplitude
//  result    m_axis_*      out        new field, old field, arithmetic fault
//  config    cfg_*         in         six q8.24 coefficients, write only
//
//  one item per cycle for distinct slots, unless result stalls or the clearing pass hold the input
//  an item whose slot is still in flight waits until that item's history write is done
//  (a result stall prolongs the wait), as the history update closes the loop
//  through the divider
//  after reset a clearing pass zeroes every history entry, with no item taken
//  a stalled result holds its stage; earlier stages keep filling bubbles
module dispersive_field_update_core #(
    parameter int POINT_COUNT = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // point_slot[9:0], acc_flux[41:10], field_now[73:42], field_before[105:74],
    // background_perm[137:106], term_amplitude[169:138], zero pad[175:170]
    input  logic [175:0]                     s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // field_new[31:0], field_old[63:32], arith_fault[64], zero pad[71:65]
    output logic [71:0]                      m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [dfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_wdata
);
    import dfu_pkg::*;

    localparam int SLOT_W = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int RED_W  = 28;
    localparam logic [RED_W-1:0] PC_R = RED_W'(POINT_COUNT);

    // coefficient registers
    logic signed [31:0] dt_reg, b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    // pipeline
    st_t               st_reg   [NUM_STG];
    st_t               res      [NUM_STG];
    logic [SLOT_W-1:0] slot_reg [NUM_STG];
    logic              vld_reg  [NUM_STG];
    logic              rdy      [NUM_STG+1];

    // history memory, {older, latest}
    logic [63:0]       hist_mem [POINT_COUNT];
    logic [63:0]       rd_reg;

    // clearing pass
    logic              clr_busy_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    // result register
    logic              out_vld_reg;
    logic signed [31:0] out_new_reg, out_old_reg;
    logic              out_flt_reg;

    logic [SLOT_W-1:0] in_slot;
    logic              hazard;
    logic              s_fire;
    logic              wb_fire;
    sat_t              pol_sat;

    // slot modulo point count, by conditional subtraction of shifted multiples
    function automatic logic [SLOT_W-1:0] slot_mod(logic [9:0] s);
        logic [RED_W-1:0] v;
        v = RED_W'(s);
        for (int k = 9; k >= 0; k--) begin
            if (v >= (PC_R << k)) v = v - (PC_R << k);
        end
        return v[SLOT_W-1:0];
    endfunction

    assign in_slot = slot_mod(s_axis_tdata[9:0]);

    // same slot still in flight: its history write has not landed yet
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < NUM_STG; k++) begin
            if (vld_reg[k] && slot_reg[k] == in_slot) hazard = 1'b1;
        end
    end

    // a stage takes new contents when it is empty or its contents move on
    always_comb begin
        rdy[NUM_STG] = !out_vld_reg || m_axis_tready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[ST_IN] && !hazard && !clr_busy_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign wb_fire       = vld_reg[NUM_STG-1] && rdy[NUM_STG];

    // stage logic
    always_comb begin
        st_t  s;
        sat_t sq, sd, sn;
        logic [31:0] mag, dmag;

        for (int k = 0; k < NUM_STG; k++) res[k] = st_reg[k];

        // item capture
        s        = st_reg[ST_IN];
        s.acc    = s_axis_tdata[41:10];
        s.e_now  = s_axis_tdata[73:42];
        s.e_prev = s_axis_tdata[105:74];
        s.g_inf  = s_axis_tdata[137:106];
        s.amp    = s_axis_tdata[169:138];
        s.fault  = 1'b0;
        res[ST_IN] = s;

        // products, history arrives from the memory read register
        s        = st_reg[ST_PROD-1];
        s.p1     = rd_reg[31:0];
        s.p2     = rd_reg[63:32];
        s.pr_be  = qmul(b1_reg, s.e_now);
        s.pr_bp  = qmul(b2_reg, s.e_prev);
        s.pr_a1  = qmul(a1_reg, rd_reg[31:0]);
        s.pr_a2  = qmul(a2_reg, rd_reg[63:32]);
        s.pr_dt  = qmul(s.acc, dt_reg);
        s.pr_ab0 = qmul(s.amp, b0_reg);
        res[ST_PROD] = s;

        // q and divisor
        s  = st_reg[ST_SUM-1];
        sq = sat32(SUM_W'(s.pr_be) + SUM_W'(s.pr_bp) - SUM_W'(s.pr_a1) - SUM_W'(s.pr_a2));
        sd = sat32(SUM_W'(s.g_inf) + SUM_W'(s.pr_ab0));
        s.q     = sq.val;
        s.den   = sd.val;
        s.fault = s.fault | sq.flt | sd.flt;
        res[ST_SUM] = s;

        s       = st_reg[ST_AQ-1];
        s.pr_aq = qmul(s.amp, s.q);
        res[ST_AQ] = s;

        s  = st_reg[ST_NUM-1];
        sn = sat32(SUM_W'(s.pr_dt) - SUM_W'(s.pr_aq));
        s.num   = sn.val;
        s.fault = s.fault | sn.flt;
        res[ST_NUM] = s;

        // divider setup: quotient of 2^32 or more counts as overflow
        s     = st_reg[ST_DSET-1];
        mag   = s.num[31] ? (~s.num + 32'd1) : s.num;
        dmag  = s.den[31] ? (~s.den + 32'd1) : s.den;
        s.dz  = (s.den == 32'sd0);
        s.ovf = ({8'd0, mag} >= {dmag, 8'd0});
        s.neg = s.num[31] ^ s.den[31];
        s.rem = {8'd0, mag[31:8]};
        s.dsh = {mag[7:0], 24'd0};
        s.dvs = dmag;
        s.quo = '0;
        res[ST_DSET] = s;

        for (int k = ST_DIV0; k < ST_DIV0 + DIV_STG; k++) begin
            res[k] = div_stage(st_reg[k-1]);
        end

        // sign, saturation and zero divisor
        s = st_reg[ST_ENEW-1];
        if (s.dz) begin
            s.fault = 1'b1;
            if (s.num > 32'sd0)      s.e_new = 32'sh7FFFFFFF;
            else if (s.num[31])      s.e_new = 32'sh80000000;
            else                     s.e_new = 32'sd0;
        end else if (s.ovf) begin
            s.fault = 1'b1;
            s.e_new = s.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (!s.neg) begin
            if (s.quo > 32'h7FFFFFFF) begin
                s.fault = 1'b1;
                s.e_new = 32'sh7FFFFFFF;
            end else begin
                s.e_new = s.quo;
            end
        end else begin
            if (s.quo > 32'h80000000) begin
                s.fault = 1'b1;
                s.e_new = 32'sh80000000;
            end else begin
                s.e_new = ~s.quo + 32'd1;
            end
        end
        res[ST_ENEW] = s;

        s        = st_reg[ST_B0E-1];
        s.pr_b0e = qmul(b0_reg, s.e_new);
        res[ST_B0E] = s;
    end

    // new latest polarization, written back as the item leaves the pipeline
    assign pol_sat = sat32(SUM_W'(st_reg[NUM_STG-1].pr_b0e) + SUM_W'(st_reg[NUM_STG-1].q));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_STG; k++) vld_reg[k] <= 1'b0;
            out_vld_reg  <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            if (rdy[ST_IN]) vld_reg[ST_IN] <= s_fire;
            for (int k = 1; k < NUM_STG; k++) begin
                if (rdy[k]) vld_reg[k] <= vld_reg[k-1];
            end
            if (rdy[NUM_STG]) out_vld_reg <= vld_reg[NUM_STG-1];
            if (clr_busy_reg) begin
                if (clr_cnt_reg == SLOT_W'(POINT_COUNT - 1)) clr_busy_reg <= 1'b0;
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
        end
    end

    // coefficient writes, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= '0;
            b0_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIME_STEP: dt_reg <= cfg_wdata;
                REG_COEF_B0:   b0_reg <= cfg_wdata;
                REG_COEF_B1:   b1_reg <= cfg_wdata;
                REG_COEF_B2:   b2_reg <= cfg_wdata;
                REG_COEF_A1:   a1_reg <= cfg_wdata;
                REG_COEF_A2:   a2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) slot_reg[ST_IN] <= in_slot;
        for (int k = 0; k < NUM_STG; k++) begin
            if (rdy[k]) st_reg[k] <= res[k];
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (rdy[k]) slot_reg[k] <= slot_reg[k-1];
        end
        if (rdy[NUM_STG]) begin
            out_new_reg <= st_reg[NUM_STG-1].e_new;
            out_old_reg <= st_reg[NUM_STG-1].e_now;
            out_flt_reg <= st_reg[NUM_STG-1].fault | pol_sat.flt;
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            hist_mem[clr_cnt_reg] <= '0;
        end else if (wb_fire) begin
            hist_mem[slot_reg[NUM_STG-1]] <= {st_reg[NUM_STG-1].p1, pol_sat.val};
        end
        if (rdy[ST_IN]) rd_reg <= hist_mem[in_slot];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_flt_reg, out_old_reg, out_new_reg};

    // checks
    a_clr_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    a_no_wb_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !vld_reg[NUM_STG-1])
        else $error("history write back during clearing pass");

    a_reset_starts_clear: assert property (@(posedge aclk)
        !aresetn |=> clr_busy_reg && !m_axis_tvalid)
        else $error("reset did not start clearing pass");

endmodule
